@@ rtl/core/rfd_pkg.sv @@
// ----------------------------------------------------------------------------
// Ranging frame deframer package
// Shared types and constants for the ranging frame deframer.
// ----------------------------------------------------------------------------
package rfd_pkg;

   localparam int POS_WIDTH = 6;

   localparam logic [7:0] START_BYTE = 8'hAA;
   localparam logic [7:0] TYPE_BYTE  = 8'h25;
   localparam logic [7:0] END_BYTE   = 8'h55;

   localparam logic [POS_WIDTH-1:0] TYPE_POS     = 6'd1;
   localparam logic [POS_WIDTH-1:0] FIRST_OFFSET = 6'd7;
   localparam logic [POS_WIDTH-1:0] CAPTURE_END  = 6'd19;

   localparam int NUM_DIST = 3;

   typedef logic [7:0]       byte_type;
   typedef logic [3:0][7:0]  word_type;
   typedef logic [POS_WIDTH-1:0] pos_type;

   typedef struct packed {
      logic                    done;
      logic                    ok;
      word_type [NUM_DIST-1:0] words;
   } frame_event_type;

endpackage

@@ rtl/core/rfd_if.sv @@
// ----------------------------------------------------------------------------
// Ranging frame deframer channels
// Valid/ready channel interfaces for received bytes and frame results.
// ----------------------------------------------------------------------------
interface rfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface rfd_rsp_if;
   logic        valid;
   logic        ready;
   logic        frame_ok;
   logic [31:0] dist_one;
   logic [31:0] dist_two;
   logic [31:0] dist_three;
   logic        have_measure;

   modport source (output valid, output frame_ok, output dist_one, output dist_two,
                   output dist_three, output have_measure, input ready);
   modport sink (input valid, input frame_ok, input dist_one, input dist_two,
                 input dist_three, input have_measure, output ready);
endinterface

@@ rtl/core/rfd_collect.sv @@
// ----------------------------------------------------------------------------
// Ranging frame collector
// Registers each received word, tracks the frame position and captures
// the three distance words of the current frame.
// ----------------------------------------------------------------------------
module rfd_collect #(
   parameter int FRAME_BYTES = 37
) (
   input  logic                     clock,
   input  logic                     reset,
   rfd_req_if.sink                  req_chan,
   input  logic                     take_ok,
   output rfd_pkg::frame_event_type frame_event
);

   localparam rfd_pkg::pos_type LastPos = rfd_pkg::POS_WIDTH'(FRAME_BYTES - 1);

   logic                in_valid_ff;
   logic                in_valid_in;
   rfd_pkg::byte_type   in_byte_ff;
   rfd_pkg::pos_type    pos_ff;
   rfd_pkg::pos_type    pos_in;
   logic                type_ff;
   logic                type_in;
   rfd_pkg::word_type   capture_ff [rfd_pkg::NUM_DIST];
   rfd_pkg::word_type   capture_in [rfd_pkg::NUM_DIST];
   rfd_pkg::pos_type    rel;
   logic                consume;

   assign consume          = in_valid_ff && take_ok;
   assign req_chan.ready   = !in_valid_ff || consume;
   assign in_valid_in      = req_chan.valid ? 1'b1 : (consume ? 1'b0 : in_valid_ff);
   assign rel              = pos_ff - rfd_pkg::FIRST_OFFSET;

   always_comb begin
      pos_in             = pos_ff;
      type_in            = type_ff;
      capture_in         = capture_ff;
      frame_event.done   = 1'b0;
      frame_event.ok     = type_ff && (in_byte_ff == rfd_pkg::END_BYTE);
      for (int i = 0; i < rfd_pkg::NUM_DIST; i++) begin
         frame_event.words[i] = capture_ff[i];
      end
      if (consume) begin
         if (pos_ff == '0) begin
            if (in_byte_ff == rfd_pkg::START_BYTE) begin
               pos_in = rfd_pkg::TYPE_POS;
            end
         end else begin
            if (pos_ff == rfd_pkg::TYPE_POS) begin
               type_in = (in_byte_ff == rfd_pkg::TYPE_BYTE);
            end
            if (pos_ff >= rfd_pkg::FIRST_OFFSET && pos_ff < rfd_pkg::CAPTURE_END) begin
               capture_in[rel[3:2]][rel[1:0]] = in_byte_ff;
            end
            if (pos_ff < LastPos) begin
               pos_in = pos_ff + 6'd1;
            end else begin
               pos_in           = '0;
               type_in          = 1'b0;
               frame_event.done = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pos_ff      <= '0;
         type_ff     <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         pos_ff      <= pos_in;
         type_ff     <= type_in;
      end
      if (req_chan.ready) begin
         in_byte_ff <= req_chan.rx_byte;
      end
      capture_ff <= capture_in;
   end

   // A completed frame always returns the collector to the idle position.
   assert property (@(posedge clock) disable iff (reset)
      frame_event.done |=> (pos_ff == '0 && !type_ff))
      else $error("collector did not return to idle after a frame");

   // The position never runs past the last byte of a frame.
   assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LastPos)
      else $error("frame position out of range");

   // A frame completes only on a word actually taken from the input register.
   assert property (@(posedge clock) disable iff (reset)
      frame_event.done |-> (in_valid_ff && take_ok && pos_ff != '0))
      else $error("frame completed without a consumed word");

endmodule

@@ rtl/core/rfd_hold.sv @@
// ----------------------------------------------------------------------------
// Ranging distance holder
// Cleans and holds the three distances of the last valid frame and
// registers one result word per completed frame.
// ----------------------------------------------------------------------------
module rfd_hold (
   input  logic                     clock,
   input  logic                     reset,
   input  rfd_pkg::frame_event_type frame_event,
   output logic                     take_ok,
   rfd_rsp_if.source                rsp_chan
);

   logic [31:0] held_ff    [rfd_pkg::NUM_DIST];
   logic [31:0] held_in    [rfd_pkg::NUM_DIST];
   logic        flag_ff;
   logic        flag_in;
   logic        out_valid_ff;
   logic        out_valid_in;
   logic        out_ok_ff;
   logic [31:0] out_dist_ff [rfd_pkg::NUM_DIST];
   logic        out_flag_ff;
   logic [31:0] cleaned    [rfd_pkg::NUM_DIST];

   assign take_ok = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      for (int i = 0; i < rfd_pkg::NUM_DIST; i++) begin
         cleaned[i] = frame_event.words[i];
         if (cleaned[i] == '0 || cleaned[i] == '1) begin
            cleaned[i] = '0;
         end
         held_in[i] = (frame_event.done && frame_event.ok) ? cleaned[i] : held_ff[i];
      end
      flag_in = (frame_event.done && frame_event.ok) ?
                ((held_in[0] != '0) || (held_in[1] != '0) || (held_in[2] != '0)) : flag_ff;
      out_valid_in = frame_event.done ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         flag_ff      <= 1'b0;
         for (int i = 0; i < rfd_pkg::NUM_DIST; i++) begin
            held_ff[i] <= '0;
         end
      end else begin
         out_valid_ff <= out_valid_in;
         flag_ff      <= flag_in;
         held_ff      <= held_in;
      end
      if (frame_event.done) begin
         out_ok_ff   <= frame_event.ok;
         out_dist_ff <= held_in;
         out_flag_ff <= flag_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.frame_ok     = out_ok_ff;
   assign rsp_chan.dist_one     = out_dist_ff[0];
   assign rsp_chan.dist_two     = out_dist_ff[1];
   assign rsp_chan.dist_three   = out_dist_ff[2];
   assign rsp_chan.have_measure = out_flag_ff;

   // A rejected frame leaves the held distances and flag untouched.
   assert property (@(posedge clock) disable iff (reset)
      (frame_event.done && !frame_event.ok) |=>
         ($stable(held_ff[0]) && $stable(held_ff[1]) && $stable(held_ff[2]) && $stable(flag_ff)))
      else $error("held values changed on a rejected frame");

   // The reported flag agrees with the reported distances.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_flag_ff ==
         ((out_dist_ff[0] != '0) || (out_dist_ff[1] != '0) || (out_dist_ff[2] != '0))))
      else $error("measurement flag disagrees with distances");

   // A completed frame is never offered while the result register is blocked.
   assert property (@(posedge clock) disable iff (reset)
      frame_event.done |-> take_ok)
      else $error("frame completed while result register was full");

endmodule

@@ rtl/core/ranging_frame_deframer_top.sv @@
// ----------------------------------------------------------------------------
// Ranging frame deframer
// Collects fixed-length ranging frames from a byte stream and reports the
// held base distances once per completed frame.
// ----------------------------------------------------------------------------
// The req_chan channel carries one received byte per word. Bytes are
// discarded until the start byte; the frame then runs for FRAME_BYTES
// bytes. Each completed frame gives one word on rsp_chan with the frame
// check result, the three held distances and the measurement flag; bytes
// that do not complete a frame give no result.
// Throughput is one byte per cycle while results are taken. A byte is held
// in the input register and is folded into the frame state as it moves on,
// so a result is registered for rsp_chan once the last byte of its frame is
// consumed. The input register and the result register each hold one word.
// When the receiver stalls with a result pending, the input register still
// takes one more byte; further bytes wait until the result is taken.
// Reset returns the block to waiting for a start byte and clears the held
// distances and flag; both channels come out of reset empty.
// ----------------------------------------------------------------------------
module ranging_frame_deframer_top #(
   parameter int FRAME_BYTES = 37
) (
   input  logic      clock,
   input  logic      reset,
   rfd_req_if.sink   req_chan,
   rfd_rsp_if.source rsp_chan
);

   rfd_pkg::frame_event_type frame_event;
   logic                     take_ok;

   rfd_collect #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_collect (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .take_ok     (take_ok),
      .frame_event (frame_event)
   );

   rfd_hold u_hold (
      .clock       (clock),
      .reset       (reset),
      .frame_event (frame_event),
      .take_ok     (take_ok),
      .rsp_chan    (rsp_chan)
   );

endmodule

@@ tb/ranging_frame_deframer_top_tb.sv @@
// ----------------------------------------------------------------------------
// Ranging frame deframer testbench
// Sends byte streams made mostly of well-formed ranging frames with random
// content, mixed with broken frames, cut-off frames and loose noise bytes.
// A scoreboard follows the frame state byte by byte, predicts the result of
// each completed frame and checks every result word as it is taken.
// ----------------------------------------------------------------------------
module ranging_frame_deframer_top_tb;

   localparam int FRAME_LEN = 37;
   localparam int QUIET_LIMIT = 2000;

   class frame_scoreboard;
      typedef struct {
         logic              ok;
         rfd_pkg::word_type one;
         rfd_pkg::word_type two;
         rfd_pkg::word_type three;
         logic              flag;
      } frame_result_type;

      rfd_pkg::pos_type  position;
      logic              type_seen;
      rfd_pkg::word_type capture [rfd_pkg::NUM_DIST];
      rfd_pkg::word_type held [rfd_pkg::NUM_DIST];
      logic              held_flag;
      frame_result_type  pending_results [$];
      int                errors;
      int                frames_checked;
      int                good_frames;

      function new();
         position = '0;
         type_seen = 1'b0;
         held_flag = 1'b0;
         foreach (held[i]) begin
            held[i] = '0;
            capture[i] = '0;
         end
         errors = 0;
         frames_checked = 0;
         good_frames = 0;
      endfunction

      function int pending_count();
         return pending_results.size();
      endfunction

      function rfd_pkg::word_type clean_distance(rfd_pkg::word_type w);
         return (w == '0 || w == '1) ? rfd_pkg::word_type'('0) : w;
      endfunction

      function void take_byte(rfd_pkg::byte_type b);
         int               rel;
         frame_result_type res;
         if (position == '0) begin
            if (b == rfd_pkg::START_BYTE) position = rfd_pkg::TYPE_POS;
            return;
         end
         if (position == rfd_pkg::TYPE_POS) type_seen = (b == rfd_pkg::TYPE_BYTE);
         if (position >= rfd_pkg::FIRST_OFFSET && position < rfd_pkg::CAPTURE_END) begin
            rel = int'(position - rfd_pkg::FIRST_OFFSET);
            capture[rel / 4][rel % 4] = b;
         end
         if (int'(position) + 1 < FRAME_LEN) begin
            position = position + 1'b1;
            return;
         end
         res.ok = type_seen && (b == rfd_pkg::END_BYTE);
         if (res.ok) begin
            foreach (held[i]) held[i] = clean_distance(capture[i]);
            held_flag = (held[0] != '0) || (held[1] != '0) || (held[2] != '0);
         end
         position = '0;
         type_seen = 1'b0;
         res.one = held[0];
         res.two = held[1];
         res.three = held[2];
         res.flag = held_flag;
         pending_results.push_back(res);
      endfunction

      function void match_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic ok, rfd_pkg::word_type one, rfd_pkg::word_type two,
                                 rfd_pkg::word_type three, logic flag);
         frame_result_type want;
         if (pending_results.size() == 0) begin
            $display({"%0t: result word with none expected, expected nothing, ",
                      "actual ok=%0b %0h %0h %0h flag=%0b"},
                     $time, ok, one, two, three, flag);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         frames_checked++;
         if (want.ok) good_frames++;
         match_field("frame_ok", 32'(want.ok), 32'(ok));
         match_field("dist_one", want.one, one);
         match_field("dist_two", want.two, two);
         match_field("dist_three", want.three, three);
         match_field("have_measure", 32'(want.flag), 32'(flag));
      endfunction
   endclass

   logic clock;
   logic reset;

   rfd_req_if req_chan ();
   rfd_rsp_if rsp_chan ();

   ranging_frame_deframer_top #(
      .FRAME_BYTES(FRAME_LEN)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   frame_scoreboard sb = new();

   bit idling_on = 1'b0;
   int stall_left = 0;
   int quiet_cycles = 0;
   int bytes_sent = 0;
   int frames_sent = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
         rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 5);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) sb.take_byte(req_chan.rx_byte);
         if (rsp_chan.valid && rsp_chan.ready) begin
            sb.check_result(rsp_chan.frame_ok, rsp_chan.dist_one, rsp_chan.dist_two,
                            rsp_chan.dist_three, rsp_chan.have_measure);
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      do @(posedge clock); while (quiet_cycles < QUIET_LIMIT);
      $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic send_byte(input rfd_pkg::byte_type b);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.rx_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      bytes_sent++;
   endtask

   task automatic send_noise(input int count);
      repeat (count) send_byte(rfd_pkg::byte_type'($urandom));
   endtask

   // Builds one frame; byte_count below FRAME_LEN cuts it short so that the
   // bytes sent next finish it instead.
   task automatic send_frame(input rfd_pkg::word_type one, input rfd_pkg::word_type two,
                             input rfd_pkg::word_type three, input bit good_type,
                             input bit good_end, input bit start_fill, input int byte_count);
      rfd_pkg::byte_type frame_bytes [FRAME_LEN];
      rfd_pkg::word_type dists [rfd_pkg::NUM_DIST];
      rfd_pkg::byte_type b;
      dists[0] = one;
      dists[1] = two;
      dists[2] = three;
      foreach (frame_bytes[i]) begin
         frame_bytes[i] = start_fill ? rfd_pkg::START_BYTE : rfd_pkg::byte_type'($urandom);
      end
      frame_bytes[0] = rfd_pkg::START_BYTE;
      if (good_type) begin
         frame_bytes[rfd_pkg::TYPE_POS] = rfd_pkg::TYPE_BYTE;
      end else begin
         do b = rfd_pkg::byte_type'($urandom); while (b == rfd_pkg::TYPE_BYTE);
         frame_bytes[rfd_pkg::TYPE_POS] = b;
      end
      for (int i = 0; i < 4 * rfd_pkg::NUM_DIST; i++) begin
         frame_bytes[int'(rfd_pkg::FIRST_OFFSET) + i] = dists[i / 4][i % 4];
      end
      if (good_end) begin
         frame_bytes[FRAME_LEN-1] = rfd_pkg::END_BYTE;
      end else begin
         do b = rfd_pkg::byte_type'($urandom); while (b == rfd_pkg::END_BYTE);
         frame_bytes[FRAME_LEN-1] = b;
      end
      for (int i = 0; i < byte_count; i++) send_byte(frame_bytes[i]);
      if (byte_count == FRAME_LEN) frames_sent++;
   endtask

   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sb.pending_count() != 0);
   endtask

   function automatic rfd_pkg::word_type pick_distance();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return 32'hFFFF_FFFE;
         3: return 32'd1;
         4: return $urandom_range(1, 20000);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_step(input bit allow_idle);
      int choice;
      choice = $urandom_range(0, 19);
      idling_on = allow_idle && ($urandom_range(0, 3) != 0);
      if (choice <= 13) begin
         send_frame(pick_distance(), pick_distance(), pick_distance(), 1'b1, 1'b1, 1'b0,
                    FRAME_LEN);
      end else if (choice <= 15) begin
         send_frame(pick_distance(), pick_distance(), pick_distance(),
                    1'($urandom_range(0, 1)), 1'b0, 1'b0, FRAME_LEN);
         send_frame(pick_distance(), pick_distance(), pick_distance(), 1'b0,
                    1'($urandom_range(0, 1)), 1'b0, FRAME_LEN);
      end else if (choice == 16) begin
         send_frame(pick_distance(), pick_distance(), pick_distance(), 1'b1, 1'b1, 1'b0,
                    $urandom_range(2, FRAME_LEN - 1));
      end else if (choice <= 18) begin
         send_noise($urandom_range(1, 8));
      end else begin
         wait_for_results();
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.rx_byte <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Loose bytes while idle are dropped, including the type and end bytes.
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(rfd_pkg::END_BYTE);
      send_byte(rfd_pkg::TYPE_BYTE);
      send_frame(32'd1000, 32'd2500, 32'hFFFF_FFFE, 1'b1, 1'b1, 1'b0, FRAME_LEN);
      send_frame(32'h0000_0001, 32'h8000_0000, 32'h1234_5678, 1'b0, 1'b1, 1'b0, FRAME_LEN);
      send_frame(32'h0000_0001, 32'h8000_0000, 32'h1234_5678, 1'b1, 1'b0, 1'b0, FRAME_LEN);
      send_frame('0, '1, '0, 1'b1, 1'b1, 1'b0, FRAME_LEN);
      send_frame('1, '0, 32'h0000_0007, 1'b1, 1'b1, 1'b0, FRAME_LEN);
      // Start bytes inside a frame are plain data and do not restart it.
      send_frame(32'hAAAA_AAAA, 32'h00AA_0000, 32'd42, 1'b1, 1'b1, 1'b1, FRAME_LEN);
      wait_for_results();

      while (bytes_sent < 820 || frames_sent < 30) random_step(1'b1);
      repeat (6) random_step(1'b0);
      idling_on = 1'b0;
      req_chan.valid <= 1'b0;

      do @(posedge clock); while (sb.pending_count() != 0);
      repeat (8) @(posedge clock);
      if (sb.pending_count() != 0) begin
         $display("%0t: results missing, expected %0d more, actual 0", $time,
                  sb.pending_count());
         sb.errors++;
      end
      $display("Sent %0d bytes with %0d whole frames plus cut-off frames and noise.",
               bytes_sent, frames_sent);
      $display("Checked %0d frame results, %0d of them with good type and end bytes.",
               sb.frames_checked, sb.good_frames);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
